FILE: rtl/cs_pkg.sv
package cs_pkg;

  // Depth of the result queue; the input is taken only while two entries are free.
  localparam int QDEPTH = 4;

  // One result byte with its end-of-text mark.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } cs_beat_t;

  // Results caused by one request: up to two bytes, first one goes out first.
  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] b0;
    logic [7:0] b1;
    logic       last;
  } cs_res_t;

endpackage

FILE: rtl/cs_if.sv
interface cs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface cs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

FILE: rtl/cs_scan.sv
module cs_scan import cs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output cs_res_t    res
);

  localparam logic [2:0] MODE_NORMAL = 3'd0;
  localparam logic [2:0] MODE_LINE   = 3'd1;
  localparam logic [2:0] MODE_BLOCK  = 3'd2;
  localparam logic [2:0] MODE_QUOTE  = 3'd3;
  localparam logic [2:0] MODE_SET    = 3'd4;

  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  logic [2:0] mode_r, mode_nxt;
  logic       dq_r, dq_nxt;
  logic       esc_r, esc_nxt;
  logic       held_r, held_nxt;
  logic       star_r, star_nxt;
  logic       plain_byte;

  always_comb begin
    mode_nxt   = mode_r;
    dq_nxt     = dq_r;
    esc_nxt    = esc_r;
    held_nxt   = held_r;
    star_nxt   = star_r;
    plain_byte = 1'b0;
    res.cnt    = 2'd1;
    res.b0     = in_byte;
    res.b1     = in_byte;
    res.last   = in_last;

    case (mode_r)
      MODE_LINE: begin
        if (in_byte == CH_NL) begin
          res.b0   = CH_NL;
          mode_nxt = MODE_NORMAL;
        end else begin
          res.b0 = CH_SPACE;
        end
      end
      MODE_BLOCK: begin
        res.b0 = (in_byte == CH_NL) ? CH_NL : CH_SPACE;
        if (star_r && in_byte == CH_SLASH) begin
          mode_nxt = MODE_NORMAL;
          star_nxt = 1'b0;
        end else begin
          star_nxt = (in_byte == CH_STAR);
        end
      end
      MODE_QUOTE, MODE_SET: begin
        if (esc_r) begin
          esc_nxt = 1'b0;
        end else if (in_byte == CH_BSLASH) begin
          esc_nxt = 1'b1;
        end else if (mode_r == MODE_SET ? (in_byte == CH_RBRACK)
                     : (in_byte == (dq_r ? CH_DQUOTE : CH_SQUOTE))) begin
          mode_nxt = MODE_NORMAL;
        end
      end
      default: begin
        if (held_r) begin
          held_nxt = 1'b0;
          res.cnt  = 2'd2;
          if (in_byte == CH_SLASH) begin
            res.b0   = CH_SPACE;
            res.b1   = CH_SPACE;
            mode_nxt = MODE_LINE;
          end else if (in_byte == CH_STAR) begin
            // The opening star never counts toward a closing star-slash.
            res.b0   = CH_SPACE;
            res.b1   = CH_SPACE;
            mode_nxt = MODE_BLOCK;
            star_nxt = 1'b0;
          end else begin
            res.b0     = CH_SLASH;
            plain_byte = 1'b1;
          end
        end else if (in_byte == CH_SLASH) begin
          // A slash on the final byte cannot start a comment, so it goes out at once.
          if (in_last) begin
            res.b0 = CH_SLASH;
          end else begin
            res.cnt  = 2'd0;
            held_nxt = 1'b1;
          end
        end else begin
          plain_byte = 1'b1;
        end
      end
    endcase

    if (plain_byte) begin
      if (in_byte == CH_LBRACK) begin
        mode_nxt = MODE_SET;
        esc_nxt  = 1'b0;
      end else if (in_byte == CH_SQUOTE || in_byte == CH_DQUOTE) begin
        mode_nxt = MODE_QUOTE;
        dq_nxt   = (in_byte == CH_DQUOTE);
        esc_nxt  = 1'b0;
      end
    end

    // Each text starts from a clean state.
    if (in_last) begin
      mode_nxt = MODE_NORMAL;
      dq_nxt   = 1'b0;
      esc_nxt  = 1'b0;
      held_nxt = 1'b0;
      star_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      dq_r   <= 1'b0;
      esc_r  <= 1'b0;
      held_r <= 1'b0;
      star_r <= 1'b0;
    end else if (acc) begin
      mode_r <= mode_nxt;
      dq_r   <= dq_nxt;
      esc_r  <= esc_nxt;
      held_r <= held_nxt;
      star_r <= star_nxt;
    end
  end

  a_held_normal: assert property (@(posedge clk) disable iff (!rst_n)
    held_r |-> mode_r == MODE_NORMAL)
    else $error("slash held outside normal text");

  a_star_block: assert property (@(posedge clk) disable iff (!rst_n)
    star_r |-> mode_r == MODE_BLOCK)
    else $error("star flag set outside a block comment");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_last |=> mode_r == MODE_NORMAL && !held_r && !esc_r && !star_r && !dq_r)
    else $error("state not cleared after end of text");

endmodule

FILE: rtl/cs_outq.sv
module cs_outq import cs_pkg::*; #(
  parameter int DEPTH = QDEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  cs_res_t  res,
  output logic     room,
  output logic     valid,
  input  logic     pop,
  output cs_beat_t head
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  cs_beat_t       mem_r [DEPTH];
  logic [AW-1:0]  wr_r, rd_r, wr1;
  logic [CW-1:0]  cnt_r, cnt_nxt, n_in, n_out;
  logic           deq;

  assign wr1   = (wr_r == AW'(DEPTH - 1)) ? '0 : wr_r + AW'(1);
  assign valid = (cnt_r != '0);
  assign head  = mem_r[rd_r];
  assign room  = (cnt_r <= CW'(DEPTH - 2));
  assign deq   = pop && valid;
  assign n_in  = push ? CW'(res.cnt) : '0;
  assign n_out = deq ? CW'(1) : '0;
  assign cnt_nxt = cnt_r + n_in - n_out;

  always_ff @(posedge clk) begin
    if (push && res.cnt != 2'd0) begin
      mem_r[wr_r].data <= res.b0;
      mem_r[wr_r].last <= res.last && (res.cnt == 2'd1);
      if (res.cnt == 2'd2) begin
        mem_r[wr1].data <= res.b1;
        mem_r[wr1].last <= res.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        if (res.cnt == 2'd1) begin
          wr_r <= wr1;
        end else if (res.cnt == 2'd2) begin
          wr_r <= (wr1 == AW'(DEPTH - 1)) ? '0 : wr1 + AW'(1);
        end
      end
      if (deq) begin
        rd_r <= (rd_r == AW'(DEPTH - 1)) ? '0 : rd_r + AW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> room)
    else $error("request taken without queue room");

endmodule

FILE: rtl/comment_stripper.sv
// A result byte is queued when its request is taken, then offered on out_s; a slash in
// normal text is held and goes out with the next request's result. Throughput: one
// byte per cycle while the queue has room; a request that flushes a held slash queues two
// bytes, and the four-entry result queue takes requests while two entries are free.
// Reset: synchronous, active low; clears the scan state and empties the queue.
module comment_stripper import cs_pkg::*; #(
  parameter int DEPTH = QDEPTH
) (
  input  logic clk,
  input  logic rst_n,
  cs_in_if.sink    in_s,
  cs_out_if.source out_s
);

  cs_res_t  res;
  cs_beat_t head;
  logic     room;
  logic     acc;

  assign in_s.ready = room;
  assign acc        = in_s.valid && room;

  cs_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .in_byte (in_s.in_byte),
    .in_last (in_s.in_last),
    .res     (res)
  );

  cs_outq #(.DEPTH(DEPTH)) u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (acc),
    .res   (res),
    .room  (room),
    .valid (out_s.valid),
    .pop   (out_s.ready),
    .head  (head)
  );

  assign out_s.out_byte = head.data;
  assign out_s.out_last = head.last;

endmodule
